// File: src/cwm_pkg.sv
// Shared types, constants and codes for the convolution window engine.
// Used by cwm_mac and conv2d_window_mac; depends on nothing.
package cwm_pkg;

  localparam int MAX_WIDTH   = 32;
  localparam int MAX_HEIGHT  = 32;
  localparam int MAX_DEPTH   = 32;
  localparam int MAX_FILTER  = 5;
  localparam int MAX_FILTERS = 32;
  localparam int MAX_STRIDE  = 5;
  localparam int MAX_PAD     = 4;

  localparam int IN_STORE_SIZE = MAX_WIDTH * MAX_HEIGHT * MAX_DEPTH;
  localparam int W_STORE_SIZE  = MAX_FILTERS * MAX_FILTER * MAX_FILTER * MAX_DEPTH;
  localparam int B_STORE_SIZE  = MAX_FILTERS;

  localparam int IN_AW = $clog2(IN_STORE_SIZE);
  localparam int W_AW  = $clog2(W_STORE_SIZE);
  localparam int B_AW  = $clog2(B_STORE_SIZE);

  localparam int DATA_W = 16;
  localparam int ACC_W  = 42;
  localparam int CFG_W  = 6;

  typedef enum logic [1:0] {
    OP_LOAD_IN  = 2'd0,
    OP_LOAD_W   = 2'd1,
    OP_LOAD_B   = 2'd2,
    OP_COMPUTE  = 2'd3
  } cwm_op_e;

  typedef enum logic [2:0] {
    CFG_IN_WIDTH    = 3'd0,
    CFG_IN_HEIGHT   = 3'd1,
    CFG_IN_DEPTH    = 3'd2,
    CFG_FILTER_SIZE = 3'd3,
    CFG_NUM_FILTERS = 3'd4,
    CFG_STRIDE      = 3'd5,
    CFG_PAD         = 3'd6
  } cwm_cfg_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_SETUP1,
    S_SETUP2,
    S_SETUP3,
    S_ROW,
    S_COL,
    S_CHAN,
    S_FLUSH,
    S_FINISH
  } cwm_state_e;

  typedef struct packed {
    cwm_op_e            op;
    logic        [14:0] index;
    logic signed [15:0] value;
    logic        [5:0]  out_x;
    logic        [5:0]  out_y;
    logic        [4:0]  filter_sel;
  } cwm_item_t;

  typedef struct packed {
    logic signed [31:0] out_value;
    logic               range_error;
    logic        [5:0]  res_x;
    logic        [5:0]  res_y;
    logic        [4:0]  res_filter;
  } cwm_result_t;

  typedef struct packed {
    logic clear;
    logic tap_valid;
  } cwm_mac_ctrl_t;

endpackage

// File: src/cwm_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
module cwm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: src/cwm_mac.sv
// Multiply-accumulate unit: one registered 16x16 multiplier, a wide accumulator,
// bias add and saturation to 32 bits. Depends on cwm_pkg.
module cwm_mac (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  cwm_pkg::cwm_mac_ctrl_t      ctrl_i,
  input  logic signed [15:0]          in_data_i,
  input  logic signed [15:0]          wt_data_i,
  input  logic signed [15:0]          bias_i,
  output logic signed [31:0]          sum_o,
  output logic                        pending_o
);
  import cwm_pkg::*;

  logic                    rd_valid_q;
  logic                    prod_valid_q;
  logic signed [31:0]      prod_q;
  logic signed [ACC_W-1:0] acc_q;
  logic signed [ACC_W-1:0] bias_ext;
  logic signed [ACC_W-1:0] total;
  logic [ACC_W-32:0]       top_bits;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_valid_q   <= 1'b0;
      prod_valid_q <= 1'b0;
    end else begin
      rd_valid_q   <= ctrl_i.tap_valid;
      prod_valid_q <= rd_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= in_data_i * wt_data_i;
    if (ctrl_i.clear) begin
      acc_q <= '0;
    end else if (prod_valid_q) begin
      acc_q <= acc_q + ACC_W'(prod_q);
    end
  end

  assign bias_ext = $signed({{(ACC_W-24){bias_i[15]}}, bias_i, 8'h00});
  assign total    = acc_q + bias_ext;
  assign top_bits = total[ACC_W-1:31];

  always_comb begin
    if ((&top_bits) || !(|top_bits)) begin
      sum_o = total[31:0];
    end else if (total[ACC_W-1]) begin
      sum_o = 32'sh8000_0000;
    end else begin
      sum_o = 32'sh7FFF_FFFF;
    end
  end

  assign pending_o = rd_valid_q | prod_valid_q;

endmodule

// File: src/conv2d_window_mac.sv
// Top level of the convolution window engine: command port, configuration
// registers, tap sequencer and the three stores. Depends on cwm_pkg, cwm_ram, cwm_mac.
//
// Usage: an item is taken when start_i is high and busy_o is low. Load items
// (input element, filter weight, bias) are written in the cycle they are taken
// and leave busy_o low, so loads can follow every cycle. A compute item raises
// busy_o until its result is formed; the result then sits on result_o, marked
// by done_o for one cycle, and the receiver cannot stall it. A new item may be
// taken in that same cycle.
// A compute item passes through the check and setup states, then for each
// filter row a row step, and for each row inside the input a column step per
// break in the column run plus one tap per channel for each column inside the
// input, then a flush that drains the multiplier. A position outside the
// output goes from the check straight to the finish state and gives a zero
// result with range_error set. The shared multiply-accumulate unit takes one
// tap per cycle while a column run lasts and sets the rate.
// Configuration writes on cfg_we_i are taken at once; write them only while idle.
// Reset sets the state and configuration registers to their defaults; store contents stay undefined.
module conv2d_window_mac (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  output logic                  busy_o,
  input  cwm_pkg::cwm_item_t    item_i,
  output logic                  done_o,
  output cwm_pkg::cwm_result_t  result_o,
  input  logic                  cfg_we_i,
  input  logic [2:0]            cfg_addr_i,
  input  logic [5:0]            cfg_wdata_i
);
  import cwm_pkg::*;

  cwm_state_e state_q, state_d;

  logic [5:0] in_width_q, in_height_q, in_depth_q, num_filters_q;
  logic [2:0] filter_size_q, stride_q, pad_q;

  logic [5:0] w_c, h_c, d_c, nf_c;
  logic [2:0] k_c, st_c, pd_c;
  logic [4:0] d_m1;

  cwm_item_t   cmd_q;
  cwm_result_t result_q, result_d;
  logic        done_q, done_d;
  logic        err_q, err_d;

  logic signed [9:0]  x0_q, x0_d, y0_q, y0_d;
  logic signed [9:0]  ix_q, ix_d, iy_q, iy_d;
  logic [7:0]         kd_q, kd_d;
  logic [10:0]        wd_q, wd_d;
  logic signed [15:0] xd_q, xd_d;
  logic [9:0]         kkd_q, kkd_d;
  logic signed [17:0] yw_q, yw_d;
  logic signed [17:0] row_ia_q, row_ia_d, col_ia_q, col_ia_d;
  logic [14:0]        wrow_q, wrow_d, wcol_q, wcol_d;
  logic [2:0]         fy_q, fy_d, fx_q, fx_d;
  logic [4:0]         c_q, c_d;

  logic [8:0]  xs, ys;
  logic [6:0]  ext_w, ext_h;
  logic        err_calc;
  logic        iy_in, ix_in, ix_next_in;
  logic signed [9:0]  ix_next;
  logic signed [17:0] ia;
  logic [14:0]        wa;

  logic                take, take_compute;
  cwm_mac_ctrl_t       mac_ctrl;
  logic                mac_pending;
  logic signed [31:0]  mac_sum;
  logic [DATA_W-1:0]   in_rdata, wt_rdata, b_rdata;

  // Register values saturated to their legal ranges.
  assign w_c  = (in_width_q == '0) ? 6'd1 :
                (in_width_q > 6'(MAX_WIDTH)) ? 6'(MAX_WIDTH) : in_width_q;
  assign h_c  = (in_height_q == '0) ? 6'd1 :
                (in_height_q > 6'(MAX_HEIGHT)) ? 6'(MAX_HEIGHT) : in_height_q;
  assign d_c  = (in_depth_q == '0) ? 6'd1 :
                (in_depth_q > 6'(MAX_DEPTH)) ? 6'(MAX_DEPTH) : in_depth_q;
  assign nf_c = (num_filters_q == '0) ? 6'd1 :
                (num_filters_q > 6'(MAX_FILTERS)) ? 6'(MAX_FILTERS) : num_filters_q;
  assign k_c  = (filter_size_q == '0) ? 3'd1 :
                (filter_size_q > 3'(MAX_FILTER)) ? 3'(MAX_FILTER) : filter_size_q;
  assign st_c = (stride_q == '0) ? 3'd1 :
                (stride_q > 3'(MAX_STRIDE)) ? 3'(MAX_STRIDE) : stride_q;
  assign pd_c = (pad_q > 3'(MAX_PAD)) ? 3'(MAX_PAD) : pad_q;
  assign d_m1 = 5'(d_c - 6'd1);

  assign take         = start_i && !busy_o;
  assign take_compute = take && (item_i.op == OP_COMPUTE);

  // A position is inside the output when pos*stride + k <= size + 2*pad.
  assign xs       = 9'({3'b0, cmd_q.out_x}) * 9'({6'b0, st_c});
  assign ys       = 9'({3'b0, cmd_q.out_y}) * 9'({6'b0, st_c});
  assign ext_w    = 7'(w_c) + 7'({pd_c, 1'b0});
  assign ext_h    = 7'(h_c) + 7'({pd_c, 1'b0});
  assign err_calc = ((10'(xs) + 10'(k_c)) > 10'(ext_w)) ||
                    ((10'(ys) + 10'(k_c)) > 10'(ext_h)) ||
                    ({1'b0, cmd_q.filter_sel} >= nf_c);

  assign iy_in      = !iy_q[9] && (iy_q[8:0] < 9'(h_c));
  assign ix_in      = !ix_q[9] && (ix_q[8:0] < 9'(w_c));
  assign ix_next    = ix_q + 10'sd1;
  assign ix_next_in = !ix_next[9] && (ix_next[8:0] < 9'(w_c));

  assign ia = col_ia_q + $signed({13'b0, c_q});
  assign wa = wcol_q + 15'(c_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      done_q        <= 1'b0;
      in_width_q    <= 6'd32;
      in_height_q   <= 6'd32;
      in_depth_q    <= 6'd3;
      filter_size_q <= 3'd5;
      num_filters_q <= 6'd16;
      stride_q      <= 3'd1;
      pad_q         <= 3'd2;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
      if (cfg_we_i) begin
        case (cwm_cfg_e'(cfg_addr_i))
          CFG_IN_WIDTH:    in_width_q    <= cfg_wdata_i;
          CFG_IN_HEIGHT:   in_height_q   <= cfg_wdata_i;
          CFG_IN_DEPTH:    in_depth_q    <= cfg_wdata_i;
          CFG_FILTER_SIZE: filter_size_q <= cfg_wdata_i[2:0];
          CFG_NUM_FILTERS: num_filters_q <= cfg_wdata_i;
          CFG_STRIDE:      stride_q      <= cfg_wdata_i[2:0];
          CFG_PAD:         pad_q         <= cfg_wdata_i[2:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_compute) begin
      cmd_q <= item_i;
    end
    result_q <= result_d;
    err_q    <= err_d;
    x0_q     <= x0_d;
    y0_q     <= y0_d;
    ix_q     <= ix_d;
    iy_q     <= iy_d;
    kd_q     <= kd_d;
    wd_q     <= wd_d;
    xd_q     <= xd_d;
    kkd_q    <= kkd_d;
    yw_q     <= yw_d;
    row_ia_q <= row_ia_d;
    col_ia_q <= col_ia_d;
    wrow_q   <= wrow_d;
    wcol_q   <= wcol_d;
    fy_q     <= fy_d;
    fx_q     <= fx_d;
    c_q      <= c_d;
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:   if (take_compute) state_d = S_CHECK;
      S_CHECK:  state_d = err_calc ? S_FINISH : S_SETUP1;
      S_SETUP1: state_d = S_SETUP2;
      S_SETUP2: state_d = S_SETUP3;
      S_SETUP3: state_d = S_ROW;
      S_ROW: begin
        if (fy_q == k_c) begin
          state_d = S_FLUSH;
        end else if (iy_in) begin
          state_d = S_COL;
        end
      end
      S_COL: begin
        if (fx_q == k_c) begin
          state_d = S_ROW;
        end else if (ix_in) begin
          state_d = S_CHAN;
        end
      end
      S_CHAN: begin
        if (c_q == d_m1) begin
          if (!((3'(fx_q + 3'd1) < k_c) && ix_next_in)) begin
            state_d = S_COL;
          end
        end
      end
      S_FLUSH:  if (!mac_pending) state_d = S_FINISH;
      S_FINISH: state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  always_comb begin
    busy_o             = (state_q != S_IDLE);
    mac_ctrl.clear     = 1'b0;
    mac_ctrl.tap_valid = 1'b0;
    done_d   = 1'b0;
    result_d = result_q;
    err_d    = err_q;
    x0_d     = x0_q;
    y0_d     = y0_q;
    ix_d     = ix_q;
    iy_d     = iy_q;
    kd_d     = kd_q;
    wd_d     = wd_q;
    xd_d     = xd_q;
    kkd_d    = kkd_q;
    yw_d     = yw_q;
    row_ia_d = row_ia_q;
    col_ia_d = col_ia_q;
    wrow_d   = wrow_q;
    wcol_d   = wcol_q;
    fy_d     = fy_q;
    fx_d     = fx_q;
    c_d      = c_q;
    case (state_q)
      S_CHECK: begin
        mac_ctrl.clear = 1'b1;
        err_d = err_calc;
        x0_d  = $signed({1'b0, xs}) - $signed({7'b0, pd_c});
        y0_d  = $signed({1'b0, ys}) - $signed({7'b0, pd_c});
      end
      S_SETUP1: begin
        kd_d = 8'(k_c) * 8'(d_c);
        wd_d = 11'(w_c) * 11'(d_c);
        xd_d = 16'(x0_q) * $signed({10'b0, d_c});
      end
      S_SETUP2: begin
        kkd_d = 10'(k_c) * 10'(kd_q);
        yw_d  = 18'(y0_q) * $signed({7'b0, wd_q});
      end
      S_SETUP3: begin
        wrow_d   = 15'(cmd_q.filter_sel) * 15'(kkd_q);
        row_ia_d = yw_q + 18'(xd_q);
        fy_d     = '0;
        iy_d     = y0_q;
      end
      S_ROW: begin
        if (fy_q != k_c) begin
          if (iy_in) begin
            col_ia_d = row_ia_q;
            wcol_d   = wrow_q;
            fx_d     = '0;
            ix_d     = x0_q;
          end else begin
            fy_d     = fy_q + 3'd1;
            iy_d     = iy_q + 10'sd1;
            row_ia_d = row_ia_q + $signed({7'b0, wd_q});
            wrow_d   = wrow_q + 15'(kd_q);
          end
        end
      end
      S_COL: begin
        if (fx_q == k_c) begin
          fy_d     = fy_q + 3'd1;
          iy_d     = iy_q + 10'sd1;
          row_ia_d = row_ia_q + $signed({7'b0, wd_q});
          wrow_d   = wrow_q + 15'(kd_q);
        end else if (ix_in) begin
          c_d = '0;
        end else begin
          fx_d     = fx_q + 3'd1;
          ix_d     = ix_next;
          col_ia_d = col_ia_q + $signed({12'b0, d_c});
          wcol_d   = wcol_q + 15'(d_c);
        end
      end
      S_CHAN: begin
        mac_ctrl.tap_valid = 1'b1;
        if (c_q == d_m1) begin
          c_d      = '0;
          fx_d     = fx_q + 3'd1;
          ix_d     = ix_next;
          col_ia_d = col_ia_q + $signed({12'b0, d_c});
          wcol_d   = wcol_q + 15'(d_c);
        end else begin
          c_d = c_q + 5'd1;
        end
      end
      S_FINISH: begin
        done_d               = 1'b1;
        result_d.out_value   = err_q ? 32'sd0 : mac_sum;
        result_d.range_error = err_q;
        result_d.res_x       = cmd_q.out_x;
        result_d.res_y       = cmd_q.out_y;
        result_d.res_filter  = cmd_q.filter_sel;
      end
      default: ;
    endcase
  end

  cwm_ram #(
    .WIDTH (DATA_W),
    .DEPTH (IN_STORE_SIZE)
  ) u_input_ram (
    .clk_i   (clk_i),
    .we_i    (take && (item_i.op == OP_LOAD_IN) && (32'(item_i.index) < IN_STORE_SIZE)),
    .waddr_i (IN_AW'(item_i.index)),
    .wdata_i (item_i.value),
    .raddr_i (IN_AW'(ia)),
    .rdata_o (in_rdata)
  );

  cwm_ram #(
    .WIDTH (DATA_W),
    .DEPTH (W_STORE_SIZE)
  ) u_weight_ram (
    .clk_i   (clk_i),
    .we_i    (take && (item_i.op == OP_LOAD_W) && (32'(item_i.index) < W_STORE_SIZE)),
    .waddr_i (W_AW'(item_i.index)),
    .wdata_i (item_i.value),
    .raddr_i (W_AW'(wa)),
    .rdata_o (wt_rdata)
  );

  cwm_ram #(
    .WIDTH (DATA_W),
    .DEPTH (B_STORE_SIZE)
  ) u_bias_ram (
    .clk_i   (clk_i),
    .we_i    (take && (item_i.op == OP_LOAD_B) && (32'(item_i.index) < B_STORE_SIZE)),
    .waddr_i (B_AW'(item_i.index)),
    .wdata_i (item_i.value),
    .raddr_i (B_AW'(cmd_q.filter_sel)),
    .rdata_o (b_rdata)
  );

  cwm_mac u_mac (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctrl_i    (mac_ctrl),
    .in_data_i ($signed(in_rdata)),
    .wt_data_i ($signed(wt_rdata)),
    .bias_i    ($signed(b_rdata)),
    .sum_o     (mac_sum),
    .pending_o (mac_pending)
  );

  assign done_o   = done_q;
  assign result_o = result_q;

endmodule
